// File: design/tcp_pkg.sv
`timescale 1ns / 1ps
package tcp_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_TILES  = 32;

  localparam int KIND_W   = 3;
  localparam int CELL_W   = 12;
  localparam int TILE_W   = 5;
  localparam int DIR_W    = 2;
  localparam int DRAW_W   = 31;
  localparam int WORD_W   = 32;
  localparam int SUPP_W   = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_IN_USE = 2'd2;

  localparam logic [6:0] RST_GRID_WIDTH   = 7'd64;
  localparam logic [6:0] RST_GRID_HEIGHT  = 7'd64;
  localparam logic [5:0] RST_TILES_IN_USE = 6'd32;

  localparam logic [KIND_W-1:0] KIND_RULE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WEIGHT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CELL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUPPORT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COLLAPSE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EXCLUDE  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE    = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DRAW_W-1:0] num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DRAW_W-1:0] quo;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: design/tcp_if.sv
`timescale 1ns / 1ps
interface tcp_req_if;
  import tcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CELL_W-1:0] cell_req;
  logic [TILE_W-1:0] tile;
  logic [DIR_W-1:0]  direction;
  logic              use_random;
  logic [DRAW_W-1:0] draw;
  logic [WORD_W-1:0] value;
  logic [WORD_W-1:0] weight_load;

  modport source (output valid, kind, cell_req, tile, direction, use_random, draw, value,
                  weight_load, input ready);
  modport sink (input valid, kind, cell_req, tile, direction, use_random, draw, value,
                weight_load, output ready);
endinterface

interface tcp_rsp_if;
  import tcp_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [TILE_W-1:0] picked_tile;
  logic [WORD_W-1:0] allowed_mask;
  logic [WORD_W-1:0] weight_total;
  logic              is_fixed;

  modport source (output valid, status, picked_tile, allowed_mask, weight_total, is_fixed,
                  input ready);
  modport sink (input valid, status, picked_tile, allowed_mask, weight_total, is_fixed,
                output ready);
endinterface

// File: design/tcp_div.sv
`timescale 1ns / 1ps
module tcp_div import tcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [4:0]        cnt;
  logic [DRAW_W-1:0] num;
  logic [WORD_W-1:0] den;
  logic [WORD_W-1:0] rem;
  logic [WORD_W:0]   sh;
  logic              fits;

  // restoring divide, one quotient bit per cycle; quotient shifts into num
  assign sh   = {rem, num[DRAW_W-1]};
  assign fits = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(DRAW_W - 1);
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? WORD_W'(sh - {1'b0, den}) : sh[WORD_W-1:0];
        num <= {num[DRAW_W-2:0], fits};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = num;
  assign rsp.rem  = rem;

endmodule

// File: design/tile_constraint_propagator.sv
`timescale 1ns / 1ps
// Loads (rule, weight, cell state, support count) pass through ST_FIN to the result.
// Collapse/exclude: a divide for the cell position, another divide for a random draw,
// a pass over the tiles for the pick and the local removal, then per popped removal
// 4 sides, each with a pass over the tiles in use; all set by the single sequencer.
// One item at a time; ready only while idle. Reset is synchronous; afterwards the
// fixed-tile store is cleared over all MAX_WIDTH*MAX_HEIGHT cells (4096 by default).
module tile_constraint_propagator import tcp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_TILES  = DEF_MAX_TILES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tcp_req_if.sink               req,
  tcp_rsp_if.source             rsp
);

  localparam int TILE_CAP  = MAX_TILES < 32 ? MAX_TILES : 32;
  localparam int CELL_CAP  = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW        = CELL_CAP > 1 ? $clog2(CELL_CAP) : 1;
  localparam int XW        = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW        = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int TIW       = $clog2(TILE_CAP);
  localparam int NTW       = $clog2(TILE_CAP + 1);
  localparam int SD        = CELL_CAP * TILE_CAP;
  localparam int STW       = $clog2(SD);
  localparam int SPW       = $clog2(SD + 1);
  localparam int EW        = XW + YW + TIW;
  localparam int SAW       = CW + 2 + TIW;
  localparam int SUP_DEPTH = CELL_CAP * 4 * (2 ** TIW);
  localparam int RW        = TIW + 2;
  localparam int PW        = YW + WW + 1;

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_DIV   = 5'd2;
  localparam logic [4:0] ST_RD    = 5'd3;
  localparam logic [4:0] ST_RDW   = 5'd4;
  localparam logic [4:0] ST_MOD   = 5'd5;
  localparam logic [4:0] ST_SCA   = 5'd6;
  localparam logic [4:0] ST_SCB   = 5'd7;
  localparam logic [4:0] ST_OK    = 5'd8;
  localparam logic [4:0] ST_DRA   = 5'd9;
  localparam logic [4:0] ST_DRB   = 5'd10;
  localparam logic [4:0] ST_WB    = 5'd11;
  localparam logic [4:0] ST_POP   = 5'd12;
  localparam logic [4:0] ST_POPW  = 5'd13;
  localparam logic [4:0] ST_NB    = 5'd14;
  localparam logic [4:0] ST_NBR   = 5'd15;
  localparam logic [4:0] ST_NBW   = 5'd16;
  localparam logic [4:0] ST_JA    = 5'd17;
  localparam logic [4:0] ST_JB    = 5'd18;
  localparam logic [4:0] ST_NWB   = 5'd19;
  localparam logic [4:0] ST_SHOW  = 5'd20;
  localparam logic [4:0] ST_SHOWD = 5'd21;
  localparam logic [4:0] ST_FIN   = 5'd22;

  function automatic logic [15:0] clampv(logic [15:0] v, logic [15:0] hi);
    logic [15:0] res;
    res = (v > hi) ? hi : v;
    if (v == 16'd0) res = 16'd1;
    return res;
  endfunction

  // configuration
  logic [6:0] gw, gh;
  logic [5:0] gt;
  logic [WW-1:0]  w_c;
  logic [HW-1:0]  h_c;
  logic [NTW-1:0] nt_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      gw <= RST_GRID_WIDTH;
      gh <= RST_GRID_HEIGHT;
      gt <= RST_TILES_IN_USE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:   gw <= cfg_data;
        CFG_GRID_HEIGHT:  gh <= cfg_data;
        CFG_TILES_IN_USE: gt <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign w_c  = WW'(clampv(16'(gw), 16'(MAX_WIDTH)));
  assign h_c  = HW'(clampv(16'(gh), 16'(MAX_HEIGHT)));
  assign nt_c = NTW'(clampv(16'(gt), 16'(TILE_CAP)));

  // sequencer state
  logic [4:0]        state;
  logic [CW-1:0]     clr;
  logic [TIW-1:0]    j;
  logic [1:0]        d;
  logic [CW-1:0]     cur;
  logic [XW-1:0]     x0, nx;
  logic [YW-1:0]     y0, ny;
  logic [TIW-1:0]    t;
  logic [TIW-1:0]    pick;
  logic [WORD_W-1:0] am, ws, rm, r;
  logic [37:0]       acc;
  logic [SPW-1:0]    sp;

  logic [KIND_W-1:0] kind_r;
  logic [CELL_W-1:0] cell_r;
  logic [TILE_W-1:0] tile_r;
  logic              rnd_r;
  logic [DRAW_W-1:0] draw_r;

  logic              res_status;
  logic [TILE_W-1:0] res_pick;
  logic [WORD_W-1:0] res_am, res_ws;
  logic              res_fx;

  logic              o_valid, o_status, o_fx;
  logic [TILE_W-1:0] o_pick;
  logic [WORD_W-1:0] o_am, o_ws;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_start;
  logic [DRAW_W-1:0] div_num;
  logic [WORD_W-1:0] div_den;

  tcp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign div_req.start = div_start;
  assign div_req.num   = div_num;
  assign div_req.den   = div_den;

  // memories
  logic [WORD_W-1:0] rule_mem [TILE_CAP*4];
  logic [WORD_W-1:0] wt_mem   [TILE_CAP];
  logic [WORD_W-1:0] am_mem   [CELL_CAP];
  logic [WORD_W-1:0] ws_mem   [CELL_CAP];
  logic [TIW:0]      fx_mem   [CELL_CAP];
  logic [SUPP_W-1:0] sup_mem  [SUP_DEPTH];
  logic [EW-1:0]     stk_mem  [SD];

  logic [WORD_W-1:0] rule_q, wt_q, am_q, ws_q;
  logic [TIW:0]      fx_q;
  logic [SUPP_W-1:0] sup_q;
  logic [EW-1:0]     stk_q;

  logic              accept;
  logic              cell_ok, tile_ok;
  logic              rule_we, wt_we, cm_we, fx_we, sup_we, stk_we;
  logic [RW-1:0]     rule_wa;
  logic [TIW-1:0]    wt_wa;
  logic [CW-1:0]     cm_wa, fx_wa;
  logic [WORD_W-1:0] cm_am, cm_ws;
  logic [TIW:0]      fx_wd;
  logic [SAW-1:0]    sup_wa, sup_ra;
  logic [SUPP_W-1:0] sup_wd, cnt;
  logic [EW-1:0]     stk_wd;
  logic              drop_cond, last_j, push_ok;
  logic [SPW-1:0]    sp_dec;

  assign accept  = req.valid && req.ready;
  assign cell_ok = 32'(req.cell_req) < 32'(CELL_CAP);
  assign tile_ok = 32'(req.tile) < 32'(TILE_CAP);
  assign last_j  = (NTW'(j) + NTW'(1)) == nt_c;
  assign sup_ra  = {cur, d[1], ~d[0], j};
  assign cnt     = sup_q - SUPP_W'(1);
  assign push_ok = sp < SPW'(SD);
  assign sp_dec  = sp - SPW'(1);
  assign drop_cond = am[j] && ((kind_r == KIND_COLLAPSE) ? (j != pick) : (j == pick));

  always_comb begin
    rule_we = accept && req.kind == KIND_RULE && tile_ok;
    rule_wa = {TIW'(req.tile), req.direction};
    wt_we   = accept && req.kind == KIND_WEIGHT && tile_ok;
    wt_wa   = TIW'(req.tile);

    cm_we = 1'b0;
    cm_wa = cur;
    cm_am = am;
    cm_ws = ws;
    if (accept && req.kind == KIND_CELL && cell_ok) begin
      cm_we = 1'b1;
      cm_wa = CW'(req.cell_req);
      cm_am = req.value;
      cm_ws = req.weight_load;
    end else if (state == ST_WB || state == ST_NWB) begin
      cm_we = 1'b1;
    end

    fx_we = 1'b0;
    fx_wa = cur;
    fx_wd = '0;
    if (state == ST_CLR) begin
      fx_we = 1'b1;
      fx_wa = clr;
    end else if (accept && req.kind == KIND_CELL && cell_ok) begin
      fx_we = 1'b1;
      fx_wa = CW'(req.cell_req);
    end else if (state == ST_OK) begin
      fx_we = 1'b1;
      fx_wd = {1'b1, pick};
    end

    sup_we = 1'b0;
    sup_wa = sup_ra;
    sup_wd = cnt;
    if (accept && req.kind == KIND_SUPPORT && cell_ok && tile_ok) begin
      sup_we = 1'b1;
      sup_wa = {CW'(req.cell_req), req.direction, TIW'(req.tile)};
      sup_wd = req.value[SUPP_W-1:0];
    end else if (state == ST_JB) begin
      sup_we = 1'b1;
    end

    stk_we = 1'b0;
    stk_wd = {x0, y0, j};
    if (state == ST_DRB && drop_cond) begin
      stk_we = push_ok;
    end else if (state == ST_JB && cnt == '0) begin
      stk_we = push_ok;
      stk_wd = {nx, ny, j};
    end
  end

  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[rule_wa] <= req.value;
    rule_q <= rule_mem[{t, d}];
    if (wt_we) wt_mem[wt_wa] <= req.value;
    wt_q <= wt_mem[j];
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      am_mem[cm_wa] <= cm_am;
      ws_mem[cm_wa] <= cm_ws;
    end
    am_q <= am_mem[cur];
    ws_q <= ws_mem[cur];
    if (fx_we) fx_mem[fx_wa] <= fx_wd;
    fx_q <= fx_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (sup_we) sup_mem[sup_wa] <= sup_wd;
    sup_q <= sup_mem[sup_ra];
    if (stk_we) stk_mem[sp[STW-1:0]] <= stk_wd;
    stk_q <= stk_mem[sp_dec[STW-1:0]];
  end

  // neighbor on the torus and its cell index
  logic [15:0] xw, yh, x0e, y0e, nxe, nye;
  logic [PW-1:0] n_full;

  always_comb begin
    xw  = 16'(w_c);
    yh  = 16'(h_c);
    x0e = 16'(x0);
    y0e = 16'(y0);
    nxe = x0e;
    nye = y0e;
    case (d)
      2'd0: nxe = (x0e == 16'd0) ? xw - 16'd1 : x0e - 16'd1;
      2'd1: nxe = (x0e + 16'd1 == xw) ? 16'd0 : x0e + 16'd1;
      2'd2: nye = (y0e == 16'd0) ? yh - 16'd1 : y0e - 16'd1;
      default: nye = (y0e + 16'd1 == yh) ? 16'd0 : y0e + 16'd1;
    endcase
    n_full = PW'(nye) * PW'(w_c) + PW'(nxe);
  end

  logic [37:0] acc_n;
  assign acc_n = acc + 38'(wt_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr       <= '0;
      sp        <= '0;
      o_valid   <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (o_valid && rsp.ready) o_valid <= 1'b0;
      if (stk_we) sp <= sp + SPW'(1);

      unique case (state)
        ST_CLR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(CELL_CAP - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            kind_r     <= req.kind;
            cell_r     <= req.cell_req;
            tile_r     <= req.tile;
            rnd_r      <= req.use_random;
            draw_r     <= req.draw;
            cur        <= CW'(req.cell_req);
            res_status <= 1'b0;
            res_pick   <= '0;
            res_am     <= '0;
            res_ws     <= '0;
            res_fx     <= 1'b0;
            unique case (req.kind) inside
              KIND_COLLAPSE, KIND_EXCLUDE: begin
                div_start <= 1'b1;
                div_num   <= DRAW_W'(req.cell_req);
                div_den   <= WORD_W'(w_c);
                state     <= ST_DIV;
              end
              KIND_READ, KIND_SPARE: state <= cell_ok ? ST_SHOW : ST_FIN;
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            x0 <= XW'(div_rsp.rem);
            y0 <= YW'(div_rsp.quo);
            if (div_rsp.quo >= DRAW_W'(h_c)) begin
              res_status <= 1'b1;
              state <= (32'(cell_r) < 32'(CELL_CAP)) ? ST_SHOW : ST_FIN;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: state <= ST_RDW;
        ST_RDW: begin
          am <= am_q;
          ws <= ws_q;
          if (rnd_r) begin
            if (ws_q == '0) begin
              res_status <= 1'b1;
              state <= ST_SHOW;
            end else begin
              div_start <= 1'b1;
              div_num   <= draw_r;
              div_den   <= ws_q;
              state     <= ST_MOD;
            end
          end else if (NTW'(tile_r) < nt_c && am_q[tile_r]) begin
            pick  <= TIW'(tile_r);
            state <= ST_OK;
          end else begin
            res_status <= 1'b1;
            state <= ST_SHOW;
          end
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            r     <= div_rsp.rem;
            acc   <= '0;
            j     <= '0;
            state <= ST_SCA;
          end
        end
        ST_SCA: state <= ST_SCB;
        ST_SCB: begin
          // cumulative weight scan over allowed tiles
          if (am[j]) acc <= acc_n;
          if (am[j] && acc_n > 38'(r)) begin
            pick  <= j;
            state <= ST_OK;
          end else if (last_j) begin
            res_status <= 1'b1;
            state <= ST_SHOW;
          end else begin
            j     <= j + TIW'(1);
            state <= ST_SCA;
          end
        end
        ST_OK: begin
          j     <= '0;
          state <= ST_DRA;
        end
        ST_DRA: state <= ST_DRB;
        ST_DRB: begin
          if (drop_cond) begin
            am[j] <= 1'b0;
            ws    <= ws - wt_q;
          end
          if (last_j) begin
            state <= ST_WB;
          end else begin
            j     <= j + TIW'(1);
            state <= ST_DRA;
          end
        end
        ST_WB: state <= ST_POP;
        ST_POP: begin
          if (sp == '0) begin
            cur   <= CW'(cell_r);
            state <= ST_SHOW;
          end else begin
            sp    <= sp_dec;
            state <= ST_POPW;
          end
        end
        ST_POPW: begin
          {x0, y0, t} <= stk_q;
          d     <= 2'd0;
          state <= ST_NB;
        end
        ST_NB: begin
          nx    <= XW'(nxe);
          ny    <= YW'(nye);
          cur   <= CW'(n_full);
          state <= ST_NBR;
        end
        ST_NBR: state <= ST_NBW;
        ST_NBW: begin
          am    <= am_q;
          ws    <= ws_q;
          rm    <= rule_q;
          j     <= '0;
          state <= ST_JA;
        end
        ST_JA: begin
          if (am[j] && rm[j]) begin
            state <= ST_JB;
          end else if (last_j) begin
            state <= ST_NWB;
          end else begin
            j <= j + TIW'(1);
          end
        end
        ST_JB: begin
          // counter hit zero: neighbor tile loses its last support
          if (cnt == '0) begin
            am[j] <= 1'b0;
            ws    <= ws - wt_q;
          end
          if (last_j) begin
            state <= ST_NWB;
          end else begin
            j     <= j + TIW'(1);
            state <= ST_JA;
          end
        end
        ST_NWB: begin
          if (d == 2'd3) begin
            state <= ST_POP;
          end else begin
            d     <= d + 2'd1;
            state <= ST_NB;
          end
        end
        ST_SHOW: state <= ST_SHOWD;
        ST_SHOWD: begin
          res_am <= am_q;
          res_ws <= ws_q;
          res_fx <= fx_q[TIW];
          if (kind_r == KIND_COLLAPSE || kind_r == KIND_EXCLUDE) begin
            res_pick <= res_status ? '0 : TILE_W'(pick);
          end else begin
            res_pick <= fx_q[TIW] ? TILE_W'(fx_q[TIW-1:0]) : '0;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_status <= res_status;
            o_pick   <= res_pick;
            o_am     <= res_am;
            o_ws     <= res_ws;
            o_fx     <= res_fx;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready        = state == ST_IDLE;
  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.picked_tile  = o_pick;
  assign rsp.allowed_mask = o_am;
  assign rsp.weight_total = o_ws;
  assign rsp.is_fixed     = o_fx;

endmodule

// File: design/tcp_checker.sv
`timescale 1ns / 1ps
module tcp_checker import tcp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_status,
  input logic [TILE_W-1:0] rsp_pick,
  input logic [WORD_W-1:0] rsp_mask,
  input logic [WORD_W-1:0] rsp_weight,
  input logic              rsp_fixed
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_pick) &&
      $stable(rsp_mask) && $stable(rsp_weight) && $stable(rsp_fixed))
    else $error("result changed while stalled");

  // store clear after reset keeps the input closed; no stale result survives reset
  a_reset: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block open right after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transfer taken while an item is in work");

endmodule

bind tile_constraint_propagator tcp_checker u_tcp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_pick   (rsp.picked_tile),
  .rsp_mask   (rsp.allowed_mask),
  .rsp_weight (rsp.weight_total),
  .rsp_fixed  (rsp.is_fixed)
);
